// ===== design/gbfc_pkg.sv =====
// Package for the GIF block walker: phase codes, markers, error codes,
// the result beat type and the color table size function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbfc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned HPOS_W  = 4;
  localparam int unsigned ERR_W   = 3;

  localparam logic [PHASE_W-1:0] PH_HEADER   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_GTABLE   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_MARKER   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_EXTLABEL = 4'd3;
  localparam logic [PHASE_W-1:0] PH_SUBLEN   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SUBDATA  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_DESC     = 4'd6;
  localparam logic [PHASE_W-1:0] PH_LTABLE   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_LZW      = 4'd8;
  localparam logic [PHASE_W-1:0] PH_DONE     = 4'd9;
  localparam logic [PHASE_W-1:0] PH_HALT     = 4'd10;

  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_SIG    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_MARKER = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NO_TRAILER = 3'd4;

  localparam logic [7:0] MK_TRAILER   = 8'h3b;
  localparam logic [7:0] MK_EXTENSION = 8'h21;
  localparam logic [7:0] MK_IMAGE     = 8'h2c;

  localparam logic [7:0] SIG_G = 8'h47;
  localparam logic [7:0] SIG_I = 8'h49;
  localparam logic [7:0] SIG_F = 8'h46;
  localparam logic [7:0] SIG_8 = 8'h38;
  localparam logic [7:0] SIG_7 = 8'h37;
  localparam logic [7:0] SIG_9 = 8'h39;
  localparam logic [7:0] SIG_A = 8'h61;

  // Header byte positions that carry meaning beyond the signature.
  localparam logic [HPOS_W-1:0] HP_WIDTH_LO  = 4'd6;
  localparam logic [HPOS_W-1:0] HP_WIDTH_HI  = 4'd7;
  localparam logic [HPOS_W-1:0] HP_HEIGHT_LO = 4'd8;
  localparam logic [HPOS_W-1:0] HP_HEIGHT_HI = 4'd9;
  localparam logic [HPOS_W-1:0] HP_PACKED    = 4'd10;
  localparam logic [HPOS_W-1:0] HP_LAST      = 4'd12;

  localparam logic [CNT_W-1:0] DESC_BYTES = 10'd9;

  typedef struct packed {
    logic [15:0]      frames_seen;
    logic [15:0]      image_width;
    logic [15:0]      image_height;
    logic             walk_done;
    logic [ERR_W-1:0] fault_code;
  } result_t;

  // Color table size in bytes: 3 * 2^(n+1), n from the low three bits.
  function automatic logic [CNT_W-1:0] table_bytes(input logic [7:0] packed_b);
    logic [CNT_W-1:0] entries;
    entries = CNT_W'(1) << ({1'b0, packed_b[2:0]} + 4'd1);
    return (entries << 1) + entries;
  endfunction

endpackage

`default_nettype wire

// ===== design/gbfc_walker.sv =====
// Byte-level walker of the GIF block structure; holds all parse state and
// forms one result per accepted byte. Depends on gbfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbfc_walker import gbfc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output result_t         result_o
);

  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [HPOS_W-1:0]      hpos_q, hpos_d;
  logic                   in_image_q, in_image_d;
  logic [COUNT_WIDTH-1:0] frame_q, frame_d;
  logic [15:0]            width_q, width_d;
  logic [15:0]            height_q, height_d;
  logic [ERR_W-1:0]       err_q, err_d;

  logic [CNT_W-1:0]       cnt_dec;
  logic [31:0]            frame_ext;

  assign cnt_dec = cnt_q - CNT_W'(1);

  always_comb begin
    logic sig_ok;
    sig_ok     = 1'b1;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    hpos_d     = hpos_q;
    in_image_d = in_image_q;
    frame_d    = frame_q;
    width_d    = width_q;
    height_d   = height_q;
    err_d      = err_q;

    if (phase_q != PH_DONE && phase_q != PH_HALT) begin
      case (phase_q)
        PH_HEADER: begin
          case (hpos_q)
            4'd0:         sig_ok = (data_byte_i == SIG_G);
            4'd1:         sig_ok = (data_byte_i == SIG_I);
            4'd2:         sig_ok = (data_byte_i == SIG_F);
            4'd3:         sig_ok = (data_byte_i == SIG_8);
            4'd4:         sig_ok = (data_byte_i == SIG_7) || (data_byte_i == SIG_9);
            4'd5:         sig_ok = (data_byte_i == SIG_A);
            HP_WIDTH_LO:  width_d[7:0]   = data_byte_i;
            HP_WIDTH_HI:  width_d[15:8]  = data_byte_i;
            HP_HEIGHT_LO: height_d[7:0]  = data_byte_i;
            HP_HEIGHT_HI: height_d[15:8] = data_byte_i;
            HP_PACKED:    cnt_d = data_byte_i[7] ? table_bytes(data_byte_i) : '0;
            default:      sig_ok = 1'b1;
          endcase
          if (!sig_ok && err_q == ERR_NONE) begin
            err_d = ERR_BAD_SIG;
          end
          if (hpos_q >= HP_LAST) begin
            if (err_d != ERR_NONE) begin
              phase_d = PH_HALT;
            end else begin
              phase_d = (cnt_q != '0) ? PH_GTABLE : PH_MARKER;
            end
          end
          hpos_d = hpos_q + HPOS_W'(1);
        end
        PH_GTABLE: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (data_byte_i == MK_TRAILER) begin
            phase_d = PH_DONE;
          end else if (data_byte_i == MK_EXTENSION) begin
            phase_d = PH_EXTLABEL;
          end else if (data_byte_i == MK_IMAGE) begin
            cnt_d   = DESC_BYTES;
            phase_d = PH_DESC;
          end else begin
            if (err_q == ERR_NONE) begin
              err_d = ERR_BAD_MARKER;
            end
            phase_d = PH_HALT;
          end
        end
        PH_EXTLABEL: begin
          in_image_d = 1'b0;
          phase_d    = PH_SUBLEN;
        end
        PH_SUBLEN: begin
          if (data_byte_i == 8'd0) begin
            // A zero-length sub-block closes the block; it counts a frame only after image data.
            if (in_image_q && frame_q != '1) begin
              frame_d = frame_q + COUNT_WIDTH'(1);
            end
            in_image_d = 1'b0;
            phase_d    = PH_MARKER;
          end else begin
            cnt_d   = CNT_W'(data_byte_i);
            phase_d = PH_SUBDATA;
          end
        end
        PH_SUBDATA: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PH_SUBLEN;
          end
        end
        PH_DESC: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            // The final descriptor byte is the packed field.
            if (data_byte_i[7]) begin
              cnt_d   = table_bytes(data_byte_i);
              phase_d = PH_LTABLE;
            end else begin
              phase_d = PH_LZW;
            end
          end
        end
        PH_LTABLE: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PH_LZW;
          end
        end
        PH_LZW: begin
          in_image_d = 1'b1;
          phase_d    = PH_SUBLEN;
        end
        default: begin
          phase_d = PH_HALT;
        end
      endcase

      if (last_byte_i && phase_d != PH_DONE && phase_d != PH_HALT) begin
        if (phase_d == PH_HEADER) begin
          err_d = ERR_TRUNCATED;
        end else if (err_d == ERR_NONE) begin
          err_d = (phase_d == PH_MARKER) ? ERR_NO_TRAILER : ERR_TRUNCATED;
        end
        phase_d = PH_HALT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      cnt_q      <= '0;
      hpos_q     <= '0;
      in_image_q <= 1'b0;
      frame_q    <= '0;
      width_q    <= '0;
      height_q   <= '0;
      err_q      <= ERR_NONE;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      hpos_q     <= hpos_d;
      in_image_q <= in_image_d;
      frame_q    <= frame_d;
      width_q    <= width_d;
      height_q   <= height_d;
      err_q      <= err_d;
    end
  end

  assign frame_ext = 32'(frame_d);

  always_comb begin
    result_o.frames_seen  = (frame_ext > 32'h0000_ffff) ? 16'hffff : frame_ext[15:0];
    result_o.image_width  = width_d;
    result_o.image_height = height_d;
    result_o.walk_done    = (phase_d == PH_DONE);
    result_o.fault_code   = err_d;
  end

endmodule

`default_nettype wire

// ===== design/gbfc_out_buf.sv =====
// Two-entry result buffer: an output register plus a skid register, so the
// walker keeps taking bytes for one beat while the sink stalls. Uses gbfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbfc_out_buf import gbfc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  result_t   push_data_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output result_t   out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = out_valid_q && out_ready_i;
  assign space_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      // Output register frees up: refill from skid first to keep order.
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        if (push_i) begin
          skid_d = push_data_i;
        end
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_d = push_data_i;
        end
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/gif_block_frame_counter.sv =====
// Top level of the GIF block walker and frame counter: joins the walker and
// the result buffer. Depends on gbfc_pkg, gbfc_walker and gbfc_out_buf.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   in       | in_valid_i/in_ready_o | data_byte_i, last_byte_i
//   out      | out_valid_o/out_ready_i | frames_seen_o, image_width_o,
//            |                       | image_height_o, walk_done_o, fault_code_o
//
// One byte is taken per cycle while the result buffer has space; each accepted
// beat yields one result beat, registered from the walker's next state.
// Reset returns the walker to the header phase with all counts cleared.
// A stalled sink is absorbed by a two-entry result buffer; input is held off
// only when both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module gif_block_frame_counter import gbfc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [15:0]           frames_seen_o,
  output logic [15:0]           image_width_o,
  output logic [15:0]           image_height_o,
  output logic                  walk_done_o,
  output logic [ERR_W-1:0]      fault_code_o
);

  logic    accept;
  logic    space;
  result_t step_result;
  result_t out_result;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  gbfc_walker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .result_o   (step_result)
  );

  gbfc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(step_result),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_result)
  );

  assign frames_seen_o  = out_result.frames_seen;
  assign image_width_o  = out_result.image_width;
  assign image_height_o = out_result.image_height;
  assign walk_done_o    = out_result.walk_done;
  assign fault_code_o   = out_result.fault_code;

endmodule

`default_nettype wire

// ===== design/gbfc_checker.sv =====
// Port-level checker for gif_block_frame_counter, attached by bind.
// Depends on gbfc_pkg; sees only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module gbfc_checker import gbfc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [15:0]      frames_seen_o,
  input wire logic [15:0]      image_width_o,
  input wire logic [15:0]      image_height_o,
  input wire logic             walk_done_o,
  input wire logic [ERR_W-1:0] fault_code_o
);

  logic             seen_q;
  logic             done_seen_q;
  logic [ERR_W-1:0] err_seen_q;
  logic [15:0]      frames_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      done_seen_q   <= 1'b0;
      err_seen_q    <= ERR_NONE;
      frames_last_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      seen_q        <= 1'b1;
      done_seen_q   <= walk_done_o;
      err_seen_q    <= fault_code_o;
      frames_last_q <= frames_seen_o;
    end
  end

  // A held result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frames_seen_o) &&
      $stable(image_width_o) && $stable(image_height_o) &&
      $stable(walk_done_o) && $stable(fault_code_o))
    else $error("result beat changed while stalled");

  // Once the trailer is reached the walk stays done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_seen_q |-> walk_done_o)
    else $error("walk_done dropped after trailer");

  // Errors are sticky, except that a header cut short turns a signature
  // error into a truncation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && err_seen_q != ERR_NONE |->
      (fault_code_o == err_seen_q) ||
      (err_seen_q == ERR_BAD_SIG && fault_code_o == ERR_TRUNCATED))
    else $error("error code changed after being set");

  // The frame count never goes backwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q |-> frames_seen_o >= frames_last_q)
    else $error("frame count decreased");

  // A finished walk carries no error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && walk_done_o |-> fault_code_o == ERR_NONE)
    else $error("walk done together with an error");

endmodule

bind gif_block_frame_counter gbfc_checker u_gbfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .frames_seen_o (frames_seen_o),
  .image_width_o (image_width_o),
  .image_height_o(image_height_o),
  .walk_done_o   (walk_done_o),
  .fault_code_o  (fault_code_o)
);

`default_nettype wire

// ===== sim/gif_block_frame_counter_test.sv =====
// Self-checking testbench for gif_block_frame_counter: one GIF stream fed as
// byte beats under random stalls on both channels, each status beat checked
// against a fixed header table or a local walker model. Depends on gbfc_pkg.
`timescale 1ns / 1ps

module gif_block_frame_counter_test;
  import gbfc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_BYTES   = 600;
  localparam int unsigned TAIL_BYTES     = 16;
  localparam int unsigned PAUSE_AT       = 100;
  localparam int unsigned CALM_ITEM_FROM = 350;
  localparam int unsigned CALM_ITEM_TO   = 500;
  localparam int unsigned HOLD_AT        = 300;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned CALM_CYC_FROM  = 700;
  localparam int unsigned CALM_CYC_TO    = 1100;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RUN_LIMIT_NS   = 2_000_000;
  localparam int unsigned LEAD_LEN       = 24;

  typedef enum int unsigned {
    END_TRAILER, END_BAD_MARKER, END_NO_TRAILER, END_CUT_SHORT
  } file_end_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } stim_t;

  // Valid header (GIF89a, width 0xffff, height 0) with a six-byte global
  // table, then one extension with a single one-byte sub-block.
  localparam stim_t LEAD_IN [LEAD_LEN] = '{
    '{data: SIG_G, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'h0000, 16'd0, 1'b0, ERR_NONE}},
    '{data: SIG_I, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'h0000, 16'd0, 1'b0, ERR_NONE}},
    '{data: SIG_F, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'h0000, 16'd0, 1'b0, ERR_NONE}},
    '{data: SIG_8, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'h0000, 16'd0, 1'b0, ERR_NONE}},
    '{data: SIG_9, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'h0000, 16'd0, 1'b0, ERR_NONE}},
    '{data: SIG_A, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'h0000, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'hff, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'h00ff, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'hff, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'hffff, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'h00, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'hffff, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'h00, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'hffff, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'h80, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'hffff, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'h00, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'hffff, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'h00, last: 1'b0, typed: 1'b1, want: '{16'd0, 16'hffff, 16'd0, 1'b0, ERR_NONE}},
    '{data: 8'h00, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'hff, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'h55, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'haa, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'h12, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'h34, last: 1'b0, typed: 1'b0, want: '0},
    '{data: MK_EXTENSION, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'hf9, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'h01, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'hff, last: 1'b0, typed: 1'b0, want: '0},
    '{data: 8'h00, last: 1'b0, typed: 1'b0, want: '0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       data_byte_i;
  logic             last_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [15:0]      frames_seen_o;
  logic [15:0]      image_width_o;
  logic [15:0]      image_height_o;
  logic             walk_done_o;
  logic [ERR_W-1:0] fault_code_o;

  stim_t       file_bytes[$];
  result_t     expected_status[$];
  int unsigned accepted_bytes = 0;
  int unsigned fail_count = 0;

  // Walker model state, starting from its reset values.
  logic [PHASE_W-1:0] walk_phase = PH_HEADER;
  logic [CNT_W-1:0]   countdown  = '0;
  logic [HPOS_W-1:0]  hdr_pos    = '0;
  logic               in_image   = 1'b0;
  logic [15:0]        frame_tally = '0;
  logic [15:0]        scr_w = '0;
  logic [15:0]        scr_h = '0;
  logic [ERR_W-1:0]   err_q = ERR_NONE;

  gif_block_frame_counter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frames_seen_o  (frames_seen_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .walk_done_o    (walk_done_o),
    .fault_code_o   (fault_code_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A color table holds 2^(n+1) entries of three bytes each.
  function automatic logic [CNT_W-1:0] color_table_len(input logic [2:0] n);
    return CNT_W'(6) << n;
  endfunction

  task automatic raise_error(input logic [ERR_W-1:0] code);
    if (err_q == ERR_NONE) err_q = code;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic last_b, output result_t res);
    logic sig_ok;
    sig_ok = 1'b1;
    if (walk_phase != PH_DONE && walk_phase != PH_HALT) begin
      case (walk_phase)
        PH_HEADER: begin
          case (hdr_pos)
            4'd0: sig_ok = (b == SIG_G);
            4'd1: sig_ok = (b == SIG_I);
            4'd2: sig_ok = (b == SIG_F);
            4'd3: sig_ok = (b == SIG_8);
            4'd4: sig_ok = (b == SIG_7) || (b == SIG_9);
            4'd5: sig_ok = (b == SIG_A);
            HP_WIDTH_LO:  scr_w[7:0]  = b;
            HP_WIDTH_HI:  scr_w[15:8] = b;
            HP_HEIGHT_LO: scr_h[7:0]  = b;
            HP_HEIGHT_HI: scr_h[15:8] = b;
            HP_PACKED:    countdown = b[7] ? color_table_len(b[2:0]) : '0;
            default: ;
          endcase
          if (!sig_ok) raise_error(ERR_BAD_SIG);
          if (hdr_pos >= HP_LAST) begin
            if (err_q != ERR_NONE) walk_phase = PH_HALT;
            else walk_phase = (countdown != '0) ? PH_GTABLE : PH_MARKER;
          end
          hdr_pos = hdr_pos + 1'b1;
        end
        PH_GTABLE: begin
          countdown = countdown - 1'b1;
          if (countdown == '0) walk_phase = PH_MARKER;
        end
        PH_MARKER: begin
          if (b == MK_TRAILER) begin
            walk_phase = PH_DONE;
          end else if (b == MK_EXTENSION) begin
            walk_phase = PH_EXTLABEL;
          end else if (b == MK_IMAGE) begin
            countdown  = DESC_BYTES;
            walk_phase = PH_DESC;
          end else begin
            raise_error(ERR_BAD_MARKER);
            walk_phase = PH_HALT;
          end
        end
        PH_EXTLABEL: begin
          in_image   = 1'b0;
          walk_phase = PH_SUBLEN;
        end
        PH_SUBLEN: begin
          if (b == 8'h00) begin
            // Only the terminator of an image's data completes a frame.
            if (in_image && frame_tally != 16'hffff) frame_tally = frame_tally + 1'b1;
            in_image   = 1'b0;
            walk_phase = PH_MARKER;
          end else begin
            countdown  = CNT_W'(b);
            walk_phase = PH_SUBDATA;
          end
        end
        PH_SUBDATA: begin
          countdown = countdown - 1'b1;
          if (countdown == '0) walk_phase = PH_SUBLEN;
        end
        PH_DESC: begin
          countdown = countdown - 1'b1;
          if (countdown == '0) begin
            if (b[7]) begin
              countdown  = color_table_len(b[2:0]);
              walk_phase = PH_LTABLE;
            end else begin
              walk_phase = PH_LZW;
            end
          end
        end
        PH_LTABLE: begin
          countdown = countdown - 1'b1;
          if (countdown == '0) walk_phase = PH_LZW;
        end
        PH_LZW: begin
          in_image   = 1'b1;
          walk_phase = PH_SUBLEN;
        end
        default: walk_phase = PH_HALT;
      endcase

      if (last_b && walk_phase != PH_DONE && walk_phase != PH_HALT) begin
        // A short header overrides a signature error.
        if (walk_phase == PH_HEADER) err_q = ERR_TRUNCATED;
        else if (walk_phase == PH_MARKER) raise_error(ERR_NO_TRAILER);
        else raise_error(ERR_TRUNCATED);
        walk_phase = PH_HALT;
      end
    end
    res = '{frame_tally, scr_w, scr_h, walk_phase == PH_DONE, err_q};
  endtask

  task automatic push_byte(input logic [7:0] d, input logic l);
    file_bytes.insert(file_bytes.size(), '{data: d, last: l, typed: 1'b0, want: '0});
  endtask

  task automatic add_sub_blocks();
    int unsigned n_blocks;
    int unsigned len;
    int unsigned roll;
    n_blocks = $urandom_range(3);
    repeat (n_blocks) begin
      roll = $urandom_range(99);
      if (roll < 4) len = 255;
      else if (roll < 12) len = $urandom_range(40, 9);
      else len = $urandom_range(8, 1);
      push_byte(8'(len), 1'b0);
      repeat (len) push_byte(8'($urandom), 1'b0);
    end
    push_byte(8'h00, 1'b0);
  endtask

  task automatic field_check(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Scoreboard: results are checked before the beat accepted at the same
  // edge is modeled, since a result always trails its byte.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t model;
    if (rst_ni === 1'b1) begin
      if (out_valid_o && out_ready_i) begin
        got = '{frames_seen_o, image_width_o, image_height_o, walk_done_o, fault_code_o};
        if (expected_status.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none expected, actual %0h", $time, got);
        end else begin
          want = expected_status.pop_front();
          field_check("frames_seen", want.frames_seen, got.frames_seen);
          field_check("image_width", want.image_width, got.image_width);
          field_check("image_height", want.image_height, got.image_height);
          field_check("walk_done", 16'(want.walk_done), 16'(got.walk_done));
          field_check("fault_code", 16'(want.fault_code), 16'(got.fault_code));
        end
      end
      if (in_valid_i && in_ready_o) begin
        walk_byte(file_bytes[accepted_bytes].data, file_bytes[accepted_bytes].last, model);
        expected_status.insert(expected_status.size(),
                               file_bytes[accepted_bytes].typed ?
                               file_bytes[accepted_bytes].want : model);
        accepted_bytes++;
      end
    end
  end

  // Sink side: random back-pressure, one long hold-off and a calm window.
  initial begin
    int unsigned cyc;
    out_ready_i = 1'b0;
    cyc = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (cyc == HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        cyc += HOLD_CYCLES;
      end
      out_ready_i <= (cyc >= CALM_CYC_FROM && cyc < CALM_CYC_TO) ||
                     ($urandom_range(99) >= 35);
      @(posedge clk_i);
      cyc++;
    end
  end

  // Source side: builds one file, then feeds it byte by byte.
  initial begin
    int unsigned idx;
    logic [2:0]  tbl_n;
    logic        has_tbl;
    logic [7:0]  flags_b;
    logic [7:0]  junk;
    stim_t       tail_beat;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;

    foreach (LEAD_IN[i]) file_bytes.insert(file_bytes.size(), LEAD_IN[i]);
    while (file_bytes.size() < LEAD_LEN + RANDOM_BYTES) begin
      if ($urandom_range(99) < 60) begin
        push_byte(MK_IMAGE, 1'b0);
        repeat (8) push_byte(8'($urandom), 1'b0);
        // Mostly small local tables; now and then up to the largest one.
        tbl_n   = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1));
        has_tbl = ($urandom_range(99) < 40);
        flags_b = {has_tbl, 4'($urandom), tbl_n};
        push_byte(flags_b, 1'b0);
        if (has_tbl) repeat (int'(color_table_len(tbl_n))) push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b0);
      end else begin
        push_byte(MK_EXTENSION, 1'b0);
        push_byte(8'($urandom), 1'b0);
      end
      add_sub_blocks();
    end

    case (file_end_e'($urandom_range(3)))
      END_TRAILER: push_byte(MK_TRAILER, 1'($urandom));
      END_BAD_MARKER: begin
        do junk = 8'($urandom);
        while (junk == MK_TRAILER || junk == MK_EXTENSION || junk == MK_IMAGE);
        push_byte(junk, 1'($urandom));
      end
      END_NO_TRAILER: begin
        tail_beat = file_bytes.pop_back();
        tail_beat.last = 1'b1;
        file_bytes.insert(file_bytes.size(), tail_beat);
      end
      default: begin
        push_byte(MK_EXTENSION, 1'b0);
        push_byte(8'hfe, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b1);
      end
    endcase
    // Bytes after the walk has stopped must leave the status unchanged.
    repeat (TAIL_BYTES) push_byte(8'($urandom), 1'($urandom));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (idx = 0; idx < file_bytes.size(); idx++) begin
      if (idx == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_status.size() != 0);
      end
      while (!(idx >= CALM_ITEM_FROM && idx < CALM_ITEM_TO) && $urandom_range(99) < 35) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= file_bytes[idx].data;
      last_byte_i <= file_bytes[idx].last;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (expected_status.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("gif_block_frame_counter verification clean");
    end else begin
      $display("gif_block_frame_counter verification failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("gif_block_frame_counter verification failed");
    $finish;
  end

endmodule
